// File: hdl/chs_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream cipher core.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package chs_pkg;

  // Rounds per keystream block (column and diagonal rounds alternate).
  localparam int unsigned CHS_ROUNDS = 20;

  // Depth of the queue between front and back; a power of two.
  localparam int unsigned CHS_QDEPTH = 2;
  localparam int unsigned CHS_QAW    = $clog2(CHS_QDEPTH);

  localparam int unsigned CHS_CFG_IW = 3;

  // Configuration register indexes.
  typedef enum logic [CHS_CFG_IW-1:0] {
    CHS_REG_KEY01 = 3'd0,
    CHS_REG_KEY23 = 3'd1,
    CHS_REG_KEY45 = 3'd2,
    CHS_REG_KEY67 = 3'd3,
    CHS_REG_NONCE = 3'd4
  } chs_reg_e;

  // "expand 32-byte k", word 0 in the low slot.
  localparam logic [3:0][31:0] CHS_SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef logic [15:0][31:0] chs_state_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic [7:0]  bmask;
    logic        last;
    logic        zero;
  } chs_item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
    logic             nonce_wr;
  } chs_cfg_t;

  // Back end status for the top level.
  typedef struct packed {
    logic gen;
    logic ks_valid;
  } chs_stat_t;

  function automatic logic [31:0] chs_rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // q[0..3] = a, b, c, d
  function automatic logic [3:0][31:0] chs_quarter(input logic [3:0][31:0] q);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = q[0];
    b = q[1];
    c = q[2];
    d = q[3];
    a = a + b; d = chs_rotl(d ^ a, 16);
    c = c + d; b = chs_rotl(b ^ c, 12);
    a = a + b; d = chs_rotl(d ^ a, 8);
    c = c + d; b = chs_rotl(b ^ c, 7);
    return {d, c, b, a};
  endfunction

  // One column round (diag = 0) or one diagonal round (diag = 1).
  function automatic chs_state_t chs_round(input chs_state_t s, input logic diag);
    chs_state_t       r;
    logic [3:0][31:0] q;
    int unsigned      ib;
    int unsigned      ic;
    int unsigned      id;
    r = s;
    for (int unsigned i = 0; i < 4; i++) begin
      ib = diag ? 4 + ((i + 1) & 3) : 4 + i;
      ic = diag ? 8 + ((i + 2) & 3) : 8 + i;
      id = diag ? 12 + ((i + 3) & 3) : 12 + i;
      q  = chs_quarter({s[id], s[ic], s[ib], s[i]});
      r[i]  = q[0];
      r[ib] = q[1];
      r[ic] = q[2];
      r[id] = q[3];
    end
    return r;
  endfunction

  // Block input state from key, block counter and nonce.
  function automatic chs_state_t chs_init(input logic [3:0][63:0] key,
                                          input logic [63:0] ctr,
                                          input logic [63:0] nonce);
    chs_state_t s;
    for (int unsigned i = 0; i < 4; i++) begin
      s[i]         = CHS_SIGMA[i];
      s[4 + 2 * i] = key[i][31:0];
      s[5 + 2 * i] = key[i][63:32];
    end
    s[12] = ctr[31:0];
    s[13] = ctr[63:32];
    s[14] = nonce[31:0];
    s[15] = nonce[63:32];
    return s;
  endfunction

endpackage

// File: hdl/chs_front.sv
// Input side of the ChaCha20 core: takes requests, classifies them and queues them.
// Depends on chs_pkg for the queue entry type and depth.
module chs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         data_in_i,
  input  logic [3:0]          byte_count_i,
  input  logic                end_of_message_i,
  output logic                q_valid_o,
  output chs_pkg::chs_item_t  q_item_o,
  input  logic                q_pop_i
);

  chs_pkg::chs_item_t               mem_q [chs_pkg::CHS_QDEPTH];
  logic [chs_pkg::CHS_QAW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [chs_pkg::CHS_QAW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [chs_pkg::CHS_QAW:0]        cnt_q, cnt_d;
  logic                             push;
  logic [3:0]                       eff_count;
  chs_pkg::chs_item_t               item;

  // Clamp counts above eight; a short chunk ends the message.
  always_comb begin
    eff_count  = byte_count_i[3] ? 4'd8 : byte_count_i;
    item.data  = data_in_i;
    item.count = eff_count;
    item.zero  = (eff_count == 4'd0);
    item.last  = end_of_message_i || (eff_count != 4'd8);
    for (int unsigned i = 0; i < 8; i++) begin
      item.bmask[i] = (eff_count > 4'(i));
    end
  end

  assign in_ready_o = (cnt_q != (chs_pkg::CHS_QAW + 1)'(chs_pkg::CHS_QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (chs_pkg::CHS_QAW + 1)'(push) - (chs_pkg::CHS_QAW + 1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// File: hdl/chs_back.sv
// Back end of the ChaCha20 core: block generator, block store, XOR and output register.
// Depends on chs_pkg for the round functions and shared types.
module chs_back #(
  parameter int unsigned ROUNDS = chs_pkg::CHS_ROUNDS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chs_pkg::chs_cfg_t   cfg_i,
  input  logic                q_valid_i,
  input  chs_pkg::chs_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         data_out_o,
  output logic [3:0]          byte_count_out_o,
  output logic                end_of_message_out_o,
  output chs_pkg::chs_stat_t  stat_o
);

  localparam int unsigned NDR = (ROUNDS + 1) / 2;   // double-round steps per block
  localparam int unsigned RCW = $clog2(NDR);
  localparam logic        ODD = (ROUNDS % 2) == 1;

  typedef enum logic {ST_RUN, ST_GEN} state_e;

  state_e              state_q, state_d;
  logic [RCW-1:0]      rc_q, rc_d;
  chs_pkg::chs_state_t w_q, w_d;
  chs_pkg::chs_state_t init;
  logic                ks_valid_q, ks_valid_d;
  logic [2:0]          off_q, off_d;
  logic [63:0]         ctr_q, ctr_d;
  logic                ovalid_q, ovalid_d;
  logic [63:0]         odata_q, odata_d;
  logic [3:0]          ocount_q, ocount_d;
  logic                olast_q, olast_d;
  logic [3:0]          lo_idx, hi_idx;
  logic [63:0]         ks;
  logic [63:0]         mask;
  logic                slot_free;

  assign init   = chs_pkg::chs_init(cfg_i.key, ctr_q, cfg_i.nonce);
  assign lo_idx = {off_q, 1'b0};
  assign hi_idx = {off_q, 1'b1};
  // The store holds the finished block, feed-forward included.
  assign ks     = {w_q[hi_idx], w_q[lo_idx]};
  assign slot_free = !ovalid_q || out_ready_i;

  always_comb begin
    for (int unsigned i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{q_item_i.bmask[i]}};
    end
  end

  always_comb begin
    state_d    = state_q;
    rc_d       = rc_q;
    w_d        = w_q;
    ks_valid_d = ks_valid_q;
    off_d      = off_q;
    ctr_d      = ctr_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;
    ocount_d   = ocount_q;
    olast_d    = olast_q;
    q_pop_o    = 1'b0;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_RUN: begin
        if (q_valid_i) begin
          if (q_item_i.zero || ks_valid_q) begin
            if (slot_free) begin
              q_pop_o  = 1'b1;
              ovalid_d = 1'b1;
              odata_d  = (q_item_i.data ^ ks) & mask;
              ocount_d = q_item_i.count;
              olast_d  = q_item_i.last;
              if (q_item_i.zero || q_item_i.last || (off_q == 3'd7)) begin
                off_d      = '0;
                ks_valid_d = 1'b0;
                if (ks_valid_q) begin
                  ctr_d = ctr_q + 64'd1;
                end
              end else begin
                off_d = off_q + 3'd1;
              end
            end
          end else begin
            w_d     = init;
            rc_d    = '0;
            state_d = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        if (ODD && (rc_q == RCW'(NDR - 1))) begin
          w_d = chs_pkg::chs_round(w_q, 1'b0);
        end else begin
          w_d = chs_pkg::chs_round(chs_pkg::chs_round(w_q, 1'b0), 1'b1);
        end
        rc_d = rc_q + 1'b1;
        if (rc_q == RCW'(NDR - 1)) begin
          // Add the input state back in; later key writes leave the block alone.
          for (int unsigned i = 0; i < 16; i++) begin
            w_d[i] = w_d[i] + init[i];
          end
          state_d    = ST_RUN;
          ks_valid_d = 1'b1;
          off_d      = '0;
        end
      end
      default: state_d = ST_RUN;
    endcase
    // New nonce: restart the counter and drop the held block.
    if (cfg_i.nonce_wr) begin
      ctr_d      = '0;
      ks_valid_d = 1'b0;
      off_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      rc_q       <= '0;
      ks_valid_q <= 1'b0;
      off_q      <= '0;
      ctr_q      <= '0;
      ovalid_q   <= 1'b0;
      odata_q    <= '0;
      ocount_q   <= '0;
      olast_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rc_q       <= rc_d;
      ks_valid_q <= ks_valid_d;
      off_q      <= off_d;
      ctr_q      <= ctr_d;
      ovalid_q   <= ovalid_d;
      odata_q    <= odata_d;
      ocount_q   <= ocount_d;
      olast_q    <= olast_d;
    end
  end

  // Working state doubles as the keystream block store.
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign out_valid_o          = ovalid_q;
  assign data_out_o           = odata_q;
  assign byte_count_out_o     = ocount_q;
  assign end_of_message_out_o = olast_q;
  assign stat_o.gen           = (state_q == ST_GEN);
  assign stat_o.ks_valid      = ks_valid_q;

endmodule

// File: hdl/chacha20_stream_cipher_core.sv
// Top level of the ChaCha20 stream cipher core (64-bit nonce, 64-bit block counter).
// Depends on chs_pkg, chs_front and chs_back; holds the key and nonce registers.
//
// The core XORs 8-byte message chunks with ChaCha20 keystream; encryption and
// decryption are the same request. Load the key with four 64-bit writes and the
// nonce with one write, little-endian; a nonce write restarts the block counter
// at zero and drops any keystream block in hand. Each input request carries up
// to eight bytes; a request marked end of message, or one with fewer than eight
// bytes, closes the message and the rest of its block is thrown away, so the
// next message starts on a fresh block. A byte count of zero returns an empty
// closing result and uses no keystream; counts above eight act as eight. Rate:
// while a block is held and the receiver takes each result, the core returns
// one chunk per cycle; a fresh block first loads the input state and then runs
// through the single double-round unit, and no chunk is returned meanwhile. A
// two-entry queue sits between the input side and the block generator, and an
// output register holds each result, so a stall on either side stops the other
// only once the queue fills or empties. Write configuration only while idle.
module chacha20_stream_cipher_core #(
  parameter int unsigned ROUNDS = chs_pkg::CHS_ROUNDS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [63:0]                     data_in_i,
  input  logic [3:0]                      byte_count_i,
  input  logic                            end_of_message_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [63:0]                     data_out_o,
  output logic [3:0]                      byte_count_out_o,
  output logic                            end_of_message_out_o,
  input  logic                            cfg_we_i,
  input  logic [chs_pkg::CHS_CFG_IW-1:0]  cfg_index_i,
  input  logic [63:0]                     cfg_wdata_i
);

  logic [3:0][63:0]   key_q;
  logic [63:0]        nonce_q;
  chs_pkg::chs_cfg_t  cfg;
  chs_pkg::chs_item_t q_item;
  chs_pkg::chs_stat_t bstat;
  logic               q_valid;
  logic               q_pop;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      case (chs_pkg::chs_reg_e'(cfg_index_i))
        chs_pkg::CHS_REG_KEY01: key_q[0] <= cfg_wdata_i;
        chs_pkg::CHS_REG_KEY23: key_q[1] <= cfg_wdata_i;
        chs_pkg::CHS_REG_KEY45: key_q[2] <= cfg_wdata_i;
        chs_pkg::CHS_REG_KEY67: key_q[3] <= cfg_wdata_i;
        chs_pkg::CHS_REG_NONCE: nonce_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Flag the nonce write in the same cycle so the counter restarts with it.
  assign cfg.key      = key_q;
  assign cfg.nonce    = nonce_q;
  assign cfg.nonce_wr = cfg_we_i &&
                        (chs_pkg::chs_reg_e'(cfg_index_i) == chs_pkg::CHS_REG_NONCE);

  chs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_in_i        (data_in_i),
    .byte_count_i     (byte_count_i),
    .end_of_message_i (end_of_message_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  chs_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .q_valid_i            (q_valid),
    .q_item_i             (q_item),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .data_out_o           (data_out_o),
    .byte_count_out_o     (byte_count_out_o),
    .end_of_message_out_o (end_of_message_out_o),
    .stat_o               (bstat)
  );

  // Block generation only runs on behalf of a queued request.
  a_gen_has_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.gen |-> q_valid)
    else $error("block generation without a queued request");

  // A nonce write drops the keystream block in hand.
  a_nonce_drops_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.nonce_wr |=> !bstat.ks_valid)
    else $error("keystream block survived a nonce write");

  // A full queue is never seen as empty by the back end.
  a_full_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full but back end sees no request");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for chacha20_stream_cipher_core: directed chunks, pressure, random traffic.
// Depends on chs_pkg for the register index codes and the default round count.
module testbench;

  // Keep the core at its default round count and predict with the same number.
  localparam int unsigned ROUND_COUNT = chs_pkg::CHS_ROUNDS;
  // Cycles a fresh block may still be in flight after the last result shows up.
  localparam int unsigned BLOCK_PAD   = 16;
  localparam int unsigned TAIL_PAD    = 40;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PHASE_ITEMS = 438;

  typedef logic [15:0][31:0] words16_t;

  // One predicted output chunk.
  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } chunk_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_in_i        = '0;
  logic [3:0]  byte_count_i     = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [63:0] data_out_o;
  logic [3:0]  byte_count_out_o;
  logic        end_of_message_out_o;
  logic        cfg_we_i         = 1'b0;
  logic [chs_pkg::CHS_CFG_IW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_wdata_i      = '0;

  // Traffic shaping knobs, set by each test.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_left       = 0;
  int unsigned errors          = 0;

  // Predictor state: its own copy of the key, nonce and keystream position.
  logic [63:0] ks_key [4];
  logic [63:0] ks_nonce;
  logic [63:0] ks_block [8];
  logic [63:0] ks_counter;
  int unsigned ks_offset;
  bit          ks_have_block;

  // Output chunks predicted but not yet seen at the output.
  chunk_t pending_chunks[$];

  chacha20_stream_cipher_core #(
    .ROUNDS(ROUND_COUNT)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_in_i           (data_in_i),
    .byte_count_i        (byte_count_i),
    .end_of_message_i    (end_of_message_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .data_out_o          (data_out_o),
    .byte_count_out_o    (byte_count_out_o),
    .end_of_message_out_o(end_of_message_out_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Keystream predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Apply one quarter round to words a, b, c, d of the working state.
  function automatic words16_t qround(input words16_t s, input int unsigned a,
                                      input int unsigned b, input int unsigned c,
                                      input int unsigned d);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
    return s;
  endfunction

  // Build the next 64-byte block from key, counter and nonce, then bump the counter.
  function automatic void next_keystream_block();
    words16_t seed;
    words16_t w;
    seed[0] = 32'h61707865;
    seed[1] = 32'h3320646e;
    seed[2] = 32'h79622d32;
    seed[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2 * i] = ks_key[i][31:0];
      seed[5 + 2 * i] = ks_key[i][63:32];
    end
    seed[12] = ks_counter[31:0];
    seed[13] = ks_counter[63:32];
    seed[14] = ks_nonce[31:0];
    seed[15] = ks_nonce[63:32];
    w = seed;
    // Even rounds work on columns, odd rounds on diagonals.
    for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
      if ((r % 2) == 0) begin
        w = qround(w, 0, 4, 8, 12);
        w = qround(w, 1, 5, 9, 13);
        w = qround(w, 2, 6, 10, 14);
        w = qround(w, 3, 7, 11, 15);
      end else begin
        w = qround(w, 0, 5, 10, 15);
        w = qround(w, 1, 6, 11, 12);
        w = qround(w, 2, 7, 8, 13);
        w = qround(w, 3, 4, 9, 14);
      end
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + seed[i];
    for (int i = 0; i < 8; i++) ks_block[i] = {w[2 * i + 1], w[2 * i]};
    ks_counter    = ks_counter + 64'd1;
    ks_offset     = 0;
    ks_have_block = 1'b1;
  endfunction

  // Predict the output of one accepted request and queue it.
  function automatic void cipher_chunk(input logic [63:0] d, input logic [3:0] cnt,
                                       input logic eom);
    chunk_t      res;
    logic [3:0]  n;
    logic [63:0] mask;
    n = (cnt > 4'd8) ? 4'd8 : cnt;
    if (n == 4'd0) begin
      // Empty chunk: close the message, drop the block, use no keystream.
      res.data      = '0;
      res.count     = '0;
      res.last      = 1'b1;
      ks_have_block = 1'b0;
      ks_offset     = 0;
    end else begin
      if (!ks_have_block) next_keystream_block();
      mask      = (n == 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      res.data  = (d ^ ks_block[ks_offset]) & mask;
      res.count = n;
      res.last  = eom || (n < 4'd8);
      ks_offset = (ks_offset + 1) % 8;
      if (ks_offset == 0) ks_have_block = 1'b0;
      if (res.last) begin
        ks_have_block = 1'b0;
        ks_offset     = 0;
      end
    end
    pending_chunks.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on each accepted request, compare each accepted result
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : scoreboard
    chunk_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) cipher_chunk(data_in_i, byte_count_i, end_of_message_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_chunks.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result: data %h count %0d last %0b",
                     data_out_o, byte_count_out_o, end_of_message_out_o);
        end else begin
          want = pending_chunks.pop_front();
          if (want.data !== data_out_o || want.count !== byte_count_out_o ||
              want.last !== end_of_message_out_o) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("result mismatch: data exp %h act %h, count exp %0d act %0d, last exp %0b act %0b",
                       want.data, data_out_o, want.count, byte_count_out_o,
                       want.last, end_of_message_out_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted down here
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the core takes it.
  task automatic send_chunk(input logic [63:0] d, input logic [3:0] cnt, input logic eom);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_in_i        <= d;
    byte_count_i     <= cnt;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, drain every predicted result, then let a late block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk_i);
    repeat (BLOCK_PAD) @(posedge clk_i);
  endtask

  // Write one register; only called while the core is idle.
  task automatic write_reg(input logic [chs_pkg::CHS_CFG_IW-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      chs_pkg::CHS_REG_KEY01: ks_key[0] = val;
      chs_pkg::CHS_REG_KEY23: ks_key[1] = val;
      chs_pkg::CHS_REG_KEY45: ks_key[2] = val;
      chs_pkg::CHS_REG_KEY67: ks_key[3] = val;
      chs_pkg::CHS_REG_NONCE: begin
        // Nonce restarts the counter and throws away any block in hand.
        ks_nonce      = val;
        ks_counter    = '0;
        ks_offset     = 0;
        ks_have_block = 1'b0;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
    write_reg(chs_pkg::CHS_REG_KEY01, k0);
    write_reg(chs_pkg::CHS_REG_KEY23, k1);
    write_reg(chs_pkg::CHS_REG_KEY45, k2);
    write_reg(chs_pkg::CHS_REG_KEY67, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed messages with random content, the rest loose requests.
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [3:0]  cnt;
    logic        eom;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int unsigned k = 1; k <= len; k++) begin
          cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
          eom = 1'b0;
          if (k == len) begin
            // Close either with the flag or with a short tail.
            if ($urandom_range(0, 1) == 1) begin
              eom = 1'b1;
            end else begin
              cnt = 4'($urandom_range(1, 7));
              eom = 1'($urandom_range(0, 1));
            end
          end
          send_chunk(rand64(), cnt, eom);
          sent++;
        end
      end else begin
        send_chunk(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Keystream from the all-zero key and nonce left by reset.
  task automatic test_reset_config();
    send_chunk(64'h0, 4'd8, 1'b1);
    wait_idle();
  endtask

  // All-ones key and nonce, all-zero and all-ones data.
  task automatic test_extreme_values();
    write_key('1, '1, '1, '1);
    write_reg(chs_pkg::CHS_REG_NONCE, '1);
    send_chunk(64'h0, 4'd8, 1'b0);
    send_chunk('1, 4'd8, 1'b1);
    wait_idle();
  endtask

  // Empty chunk dropping a held block, counts above eight, short tails.
  task automatic test_byte_counts();
    write_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
              64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    write_reg(chs_pkg::CHS_REG_NONCE, 64'h4a00000000000000);
    send_chunk(rand64(), 4'd8, 1'b0);
    send_chunk('1, 4'd0, 1'b0);
    send_chunk(rand64(), 4'd9, 1'b0);
    send_chunk(rand64(), 4'd15, 1'b0);
    send_chunk('1, 4'd1, 1'b0);
    send_chunk(rand64(), 4'd4, 1'b0);
    send_chunk('1, 4'd7, 1'b1);
    wait_idle();
  endtask

  // Eight chunks use up one block; the ninth must start the next one.
  task automatic test_block_rollover();
    for (int i = 0; i < 9; i++) send_chunk(rand64(), 4'd8, (i == 8));
    wait_idle();
  endtask

  // Key write keeps the held block; nonce write drops it and restarts the counter.
  task automatic test_mid_message_writes();
    send_chunk(rand64(), 4'd8, 1'b0);
    send_chunk(rand64(), 4'd8, 1'b0);
    wait_idle();
    write_key(rand64(), rand64(), rand64(), rand64());
    send_chunk(rand64(), 4'd8, 1'b0);
    send_chunk(rand64(), 4'd8, 1'b0);
    wait_idle();
    write_reg(chs_pkg::CHS_REG_NONCE, rand64());
    send_chunk(rand64(), 4'd8, 1'b1);
    wait_idle();
  endtask

  // Indexes past the nonce register must leave the configuration alone.
  task automatic test_spare_indexes();
    for (int i = int'(chs_pkg::CHS_REG_NONCE) + 1; i < (1 << chs_pkg::CHS_CFG_IW); i++)
      write_reg(chs_pkg::CHS_CFG_IW'(i), rand64());
    send_chunk(rand64(), 4'd8, 1'b1);
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps pushing, so the input stalls.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    @(negedge clk_i);
    hold_left = 400;
    for (int i = 0; i < 24; i++) send_chunk(rand64(), 4'd8, (i == 23));
    wait_idle();
  endtask

  // One phase of random traffic under fresh random key and nonce.
  task automatic test_traffic_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    write_key(rand64(), rand64(), rand64(), rand64());
    write_reg(chs_pkg::CHS_REG_NONCE, rand64());
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    run_traffic(PHASE_ITEMS);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    ks_key[0]     = '0;
    ks_key[1]     = '0;
    ks_key[2]     = '0;
    ks_key[3]     = '0;
    ks_nonce      = '0;
    ks_counter    = '0;
    ks_offset     = 0;
    ks_have_block = 1'b0;
    for (int i = 0; i < 8; i++) ks_block[i] = '0;

    // Hold reset, then release it away from the rising edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (BLOCK_PAD) @(posedge clk_i);

    test_reset_config();
    test_extreme_values();
    test_byte_counts();
    test_block_rollover();
    test_mid_message_writes();
    test_spare_indexes();
    test_backpressure();
    test_traffic_phase(0, 0);
    test_traffic_phase(62, 0);
    test_traffic_phase(0, 62);
    test_traffic_phase(27, 27);

    // Catch any stray result after the last expected one.
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (TAIL_PAD) @(posedge clk_i);
    if (errors == 0 && pending_chunks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hdl/chs_pkg.sv
hdl/chs_front.sv
hdl/chs_back.sv
hdl/chacha20_stream_cipher_core.sv
tb/testbench.sv
